// File: hdl/gfam_pkg.sv
// shared types and constants for the gain/fade audio mixer
// no dependencies; imported by gfam_ctrl, gfam_dp and the top level

package gfam_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int POS_W     = 2;
    localparam int INDEX_W   = 10;
    localparam int LEN_W     = 10;
    localparam int PROD_W    = SAMPLE_W + GAIN_W;     // signed sample * gain
    localparam int MAG_W     = PROD_W - 1;            // magnitude fits in 31 bits
    localparam int SCALED_W  = MAG_W + LEN_W;         // magnitude * ramp numerator
    localparam int GAIN_FRAC = 12;                    // q4.12 gain
    localparam int DIVD_W    = SCALED_W - GAIN_FRAC;  // dividend after the q4.12 shift
    localparam int ACC_W     = 24;
    localparam int OUT_W     = 16;
    localparam int DIV_STEPS = DIVD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(256);

    // chunk position classes
    localparam logic [POS_W-1:0] POS_NONE   = 2'd0;
    localparam logic [POS_W-1:0] POS_START  = 2'd1;
    localparam logic [POS_W-1:0] POS_MIDDLE = 2'd2;
    localparam logic [POS_W-1:0] POS_END    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_DIV,
        S_ACC,
        S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic mul;
        logic scale;
        logic div_step;
        logic acc_add;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;
        logic div_last;
        logic out_busy;
    } t_dp_sts;

endpackage

// File: hdl/gfam_ctrl.sv
// sequencing state machine for the gain/fade audio mixer
// depends on gfam_pkg (state type, command and status structs)

module gfam_ctrl
    import gfam_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_state       = i_sts.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                // hold until the output register can take the sum
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_in |=> r_state == S_MUL)
        else $error("accepted transaction did not start the multiply");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> $past(r_state) == S_ACC || $past(r_state) == S_EMIT)
        else $error("finish issued without passing the accumulate step");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && !i_sts.div_last |=> r_state == S_DIV)
        else $error("divider left before its last step");

endmodule

// File: hdl/gfam_dp.sv
// datapath of the gain/fade audio mixer: multipliers, serial divider,
// accumulator, output register and chunk length register; uses gfam_pkg

module gfam_dp
    import gfam_pkg::*;
#(
    parameter int MAX_CHUNK = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [LEN_W-1:0]           i_cfg_wr_data,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic signed [GAIN_W-1:0]   i_gain,
    input  logic [POS_W-1:0]           i_position,
    input  logic [INDEX_W-1:0]         i_sample_index,
    input  logic                       i_last_channel,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic signed [OUT_W-1:0]    o_mixed,
    input  t_dp_cmd                    i_cmd,
    output t_dp_sts                    o_sts
);

    localparam int LEN_MAX_I = (MAX_CHUNK - 1 > (2 ** LEN_W) - 1) ?
                               (2 ** LEN_W) - 1 : MAX_CHUNK - 1;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_MAX_I);

    logic [LEN_W-1:0]           r_len_cfg;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [GAIN_W-1:0]   r_gain;
    logic [POS_W-1:0]           r_pos;
    logic [INDEX_W-1:0]         r_idx;
    logic                       r_last;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_neg;
    logic [DIVD_W-1:0]          r_quo;
    logic [LEN_W-1:0]           r_rem;
    logic [CNT_W-1:0]           r_cnt;
    logic [ACC_W-1:0]           r_acc;
    logic                       r_any;
    logic                       r_out_valid;
    logic signed [OUT_W-1:0]    r_mixed;

    logic [LEN_W-1:0]    len_eff;
    logic [LEN_W-1:0]    idx_sat;
    logic [LEN_W-1:0]    num;
    logic [PROD_W-1:0]   prod_abs;
    logic [SCALED_W-1:0] scaled;
    logic [LEN_W:0]      trial;
    logic                trial_ge;
    logic [ACC_W-1:0]    q_ext;
    logic [ACC_W-1:0]    contrib;
    logic signed [OUT_W-1:0] sat;

    // effective ramp length: zero reads as one, clamped below the chunk limit
    always_comb begin
        if (r_len_cfg == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_len_cfg > LEN_CAP) begin
            len_eff = LEN_CAP;
        end else begin
            len_eff = r_len_cfg;
        end
    end

    // ramp numerator
    always_comb begin
        idx_sat = (r_idx > len_eff) ? len_eff : r_idx;
        case (r_pos)
            POS_START: num = idx_sat;
            POS_END:   num = len_eff - idx_sat;
            default:   num = len_eff;
        endcase
    end

    assign prod_abs = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign scaled   = prod_abs[MAG_W-1:0] * num;

    assign trial    = {r_rem, r_quo[DIVD_W-1]};
    assign trial_ge = trial >= {1'b0, len_eff};

    assign q_ext   = r_quo[ACC_W-1:0];
    assign contrib = r_neg ? ACC_W'(-q_ext) : q_ext;

    // saturate the signed 24-bit sum to 16 bits
    always_comb begin
        if (!r_acc[ACC_W-1] && (r_acc[ACC_W-2:OUT_W-1] != '0)) begin
            sat = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (r_acc[ACC_W-1] && (r_acc[ACC_W-2:OUT_W-1] != '1)) begin
            sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            sat = r_acc[OUT_W-1:0];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= i_sample;
            r_gain   <= i_gain;
            r_pos    <= i_position;
            r_idx    <= i_sample_index;
            r_last   <= i_last_channel;
        end
        if (i_cmd.mul) begin
            r_prod <= r_sample * r_gain;
        end
        if (i_cmd.scale) begin
            r_neg <= r_prod[PROD_W-1];
            r_quo <= scaled[SCALED_W-1:GAIN_FRAC];
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? LEN_W'(trial - {1'b0, len_eff}) : trial[LEN_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], trial_ge};
        end
        if (i_cmd.finish && r_any) begin
            r_mixed <= sat;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg   <= LEN_RESET;
            r_cnt       <= '0;
            r_acc       <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_len_cfg <= i_cfg_wr_data;
            end
            if (i_cmd.scale) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.acc_add && (r_pos != POS_NONE)) begin
                r_acc <= r_acc + contrib;
                r_any <= 1'b1;
            end else if (i_cmd.finish) begin
                r_acc <= '0;
                r_any <= 1'b0;
            end
            if (i_cmd.finish && r_any) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mixed        = r_mixed;
    assign o_sts.last     = r_last;
    assign o_sts.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.div_step) |-> r_rem < len_eff)
        else $error("divider remainder not below the chunk length");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_acc == '0 && !r_any)
        else $error("accumulator not cleared after the last channel");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.finish) && $past(r_any))
        else $error("output raised without an active position");

endmodule

// File: hdl/gain_fade_audio_mixer_unit.sv
// top level of the gain/fade audio mixer: stream ports and configuration
// depends on gfam_pkg, gfam_ctrl and gfam_dp

// Mixes channels one transaction at a time for a single sample position. Each
// input transaction carries a signed sample, a signed q4.12 gain, a chunk
// class in tuser (0 none, 1 start fade-in, 2 middle, 3 end fade-out) and the
// sample index within the chunk; tlast marks the final channel of the
// position. The contribution sample*gain/4096, scaled by index/len on a
// start chunk or (len-index)/len on an end chunk, is truncated toward zero
// and added to a 24-bit wrapping accumulator. On the last channel, if any
// channel was not of class none, one output transaction carries the sum
// saturated to signed 16 bits; the accumulator clears either way. The ramp
// length is written through i_cfg_wr_en/i_cfg_wr_data (reset 256, zero acts
// as one, clamped to MAX_CHUNK-1) and should be changed only while idle.
// Each input transaction passes the multiply, scale, divide and accumulate
// steps before the next one can be accepted, plus an emit step on the last
// channel of a position. The 29-step restoring divider divides the scaled
// product by the ramp length one quotient bit per cycle. The result sits in
// an output register so the next position can start while it waits; a last
// channel stalls only while an earlier result is still not taken.

module gain_fade_audio_mixer_unit
    import gfam_pkg::*;
#(
    parameter int MAX_CHUNK = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_cfg_wr_en,
    input  logic [LEN_W-1:0] i_cfg_wr_data,
    // input stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [47:0]      s_axis_tdata,  // sample [15:0], gain [31:16],
                                            // sample_index [41:32], zero pad
    input  logic [POS_W-1:0] s_axis_tuser,  // position [1:0]
    input  logic             s_axis_tlast,  // last_channel
    // output stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata   // mixed [15:0]
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic signed [OUT_W-1:0] mixed;

    // sequencer: accepts a transaction, then steps the datapath through
    // multiply, scale, divide, accumulate and (on the last channel) emit
    gfam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // arithmetic, accumulator and the output register
    gfam_dp #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_sample       (s_axis_tdata[SAMPLE_W-1:0]),
        .i_gain         (s_axis_tdata[SAMPLE_W+GAIN_W-1:SAMPLE_W]),
        .i_position     (s_axis_tuser),
        .i_sample_index (s_axis_tdata[SAMPLE_W+GAIN_W+INDEX_W-1:SAMPLE_W+GAIN_W]),
        .i_last_channel (s_axis_tlast),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_mixed        (mixed),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

    assign m_axis_tdata = mixed;

endmodule

// File: tb/gain_fade_audio_mixer_unit_test.sv
// self-checking testbench for the gain/fade audio mixer
// depends on gfam_pkg and gain_fade_audio_mixer_unit; nothing else is read

`timescale 1ns / 1ps

module gain_fade_audio_mixer_unit_test
    import gfam_pkg::*;
();

    localparam int MIX_MAX_CHUNK = 1024;
    localparam int SETTLE_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 850;
    localparam int PHASES = 7;
    localparam longint OUT_MAX = 32767;
    localparam longint OUT_MIN = -32768;

    // one channel transaction; pinned rows carry their own expected result
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smp;
        logic signed [GAIN_W-1:0]   gn;
        logic [POS_W-1:0]           pos;
        logic [INDEX_W-1:0]         idx;
        logic                       last;
        logic                       pinned;
        logic                       emits;
        logic signed [OUT_W-1:0]    mixed;
    } t_mix_row;

    // directed rows, ramp length at its reset value of 256
    localparam int DIRECTED_COUNT = 22;
    localparam t_mix_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // unity gain passes full scale straight through
        '{16'sh7FFF, 16'sh1000, POS_MIDDLE, 10'd0,    1'b1, 1'b1, 1'b1, 16'sh7FFF},
        // middle ignores the index
        '{16'sh8000, 16'sh1000, POS_MIDDLE, 10'h3FF,  1'b1, 1'b1, 1'b1, 16'sh8000},
        // two full-scale channels saturate high
        '{16'sh7FFF, 16'sh7FFF, POS_MIDDLE, 10'd0,    1'b0, 1'b1, 1'b0, 16'sh0000},
        '{16'sh7FFF, 16'sh7FFF, POS_MIDDLE, 10'd0,    1'b1, 1'b1, 1'b1, 16'sh7FFF},
        // most negative times most negative
        '{16'sh8000, 16'sh8000, POS_MIDDLE, 10'd0,    1'b1, 1'b1, 1'b1, 16'sh7FFF},
        // end ramp at index zero is full, saturates low
        '{16'sh8000, 16'sh7FFF, POS_END,    10'd0,    1'b1, 1'b1, 1'b1, 16'sh8000},
        // a position of class none only: nothing comes out
        '{16'sd1000, 16'sh1000, POS_NONE,   10'd5,    1'b0, 1'b1, 1'b0, 16'sh0000},
        '{16'sd0,    16'sh0000, POS_NONE,   10'd0,    1'b1, 1'b1, 1'b0, 16'sh0000},
        // start ramp at zero is active but adds nothing
        '{16'sd1000, 16'sh1000, POS_START,  10'd0,    1'b1, 1'b1, 1'b1, 16'sd0},
        '{16'sd1000, 16'sh1000, POS_START,  10'd128,  1'b1, 1'b1, 1'b1, 16'sd500},
        '{16'sd1000, 16'sh1000, POS_END,    10'd64,   1'b1, 1'b1, 1'b1, 16'sd750},
        // index beyond the length: start tops out, end bottoms out
        '{16'sd1000, 16'sh1000, POS_START,  10'h3FF,  1'b0, 1'b1, 1'b0, 16'sd0},
        '{16'sd1000, 16'sh1000, POS_END,    10'h3FF,  1'b1, 1'b1, 1'b1, 16'sd1000},
        // half gain on an odd negative sample truncates toward zero
        '{-16'sd1001, 16'sh0800, POS_MIDDLE, 10'd0,   1'b1, 1'b1, 1'b1, -16'sd500},
        // tiny negative contribution, then a none channel closes the position
        '{-16'sd3,   16'sh1000, POS_START,  10'd1,    1'b0, 1'b0, 1'b0, 16'sd0},
        '{16'sd1000, 16'sh1000, POS_NONE,   10'd0,    1'b1, 1'b1, 1'b1, 16'sd0},
        // alternating bit patterns
        '{16'sh5555, 16'shAAAA, POS_START,  10'h2AA,  1'b0, 1'b0, 1'b0, 16'sd0},
        '{16'shAAAA, 16'sh5555, POS_END,    10'h155,  1'b1, 1'b0, 1'b0, 16'sd0},
        '{16'sh1234, 16'sh0001, POS_MIDDLE, 10'd0,    1'b1, 1'b0, 1'b0, 16'sd0},
        // gain of minus one lsb
        '{16'sh7FFF, 16'shFFFF, POS_MIDDLE, 10'd0,    1'b1, 1'b1, 1'b1, -16'sd7},
        '{16'sd12345, 16'sh1000, POS_START, 10'd255,  1'b1, 1'b0, 1'b0, 16'sd0},
        // end ramp with the index equal to the length
        '{16'sd12345, 16'sh1000, POS_END,   10'd256,  1'b1, 1'b1, 1'b1, 16'sd0}
    };

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_wr_en    = 1'b0;
    logic [LEN_W-1:0]      i_cfg_wr_data  = '0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata   = '0;  // sample [15:0], gain [31:16],
                                                 // sample_index [41:32], zero pad
    logic [POS_W-1:0]      s_axis_tuser   = '0;  // position [1:0]
    logic                  s_axis_tlast   = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;         // mixed [15:0]

    // predictor state: its own copy of the ramp length and the running sum
    logic [LEN_W-1:0]      ramp_len    = LEN_RESET;
    logic [ACC_W-1:0]      mix_acc     = '0;
    bit                    mix_active  = 1'b0;

    logic signed [OUT_W-1:0] pending_mix [$];
    int                    mismatch_count = 0;
    int                    sent_items     = 0;
    int                    tx_idle_pct    = 34;
    int                    rx_idle_pct    = 68;
    int                    quiet_cycles   = 0;

    gain_fade_audio_mixer_unit #(
        .MAX_CHUNK (MIX_MAX_CHUNK)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one channel into the predictor; returns 1 when the position emits a sample
    function automatic bit mix_channel(input logic signed [SAMPLE_W-1:0] smp,
                                       input logic signed [GAIN_W-1:0] gn,
                                       input logic [POS_W-1:0] pos,
                                       input logic [INDEX_W-1:0] idx,
                                       input logic last,
                                       output logic signed [OUT_W-1:0] mixed);
        longint len, num, prod, mag, quo, total;
        bit emit;
        emit = 1'b0;
        mixed = '0;
        // zero length behaves as one, anything too long is clamped
        len = longint'(ramp_len);
        if (len == 0)
            len = 1;
        if (len > MIX_MAX_CHUNK - 1)
            len = MIX_MAX_CHUNK - 1;
        if (pos != POS_NONE) begin
            prod = longint'(smp) * longint'(gn);
            mag = (prod < 0) ? -prod : prod;
            num = (longint'(idx) > len) ? len : longint'(idx);
            if (pos == POS_END)
                num = len - num;
            else if (pos == POS_MIDDLE)
                num = len;
            // exact rational value, truncated toward zero on the magnitude
            quo = (mag * num) / (len * 4096);
            if (prod < 0)
                quo = -quo;
            mix_acc = mix_acc + ACC_W'(quo);
            mix_active = 1'b1;
        end
        if (last) begin
            total = longint'($signed(mix_acc));
            emit = mix_active;
            if (total > OUT_MAX)
                total = OUT_MAX;
            else if (total < OUT_MIN)
                total = OUT_MIN;
            mixed = OUT_W'(total);
            mix_acc = '0;
            mix_active = 1'b0;
        end
        return emit;
    endfunction

    // present one channel, wait for the handshake, then predict
    task automatic send_row(input t_mix_row r);
        logic signed [OUT_W-1:0] predicted;
        bit emits;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, r.idx, r.gn, r.smp};
        s_axis_tuser  <= r.pos;
        s_axis_tlast  <= r.last;
        do @(posedge i_clk); while (!s_axis_tready);
        emits = mix_channel(r.smp, r.gn, r.pos, r.idx, r.last, predicted);
        if (r.pinned) begin
            emits = r.emits;
            predicted = r.mixed;
        end
        if (emits)
            pending_mix.push_back(predicted);
        sent_items++;
    endtask

    // hold the input side until every expected sample has left the block
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (pending_mix.size() != 0)
            @(posedge i_clk);
        // a position that emits nothing may still be in the divider
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one random sample position: mostly well-formed mixes, some noise
    task automatic send_random_position();
        t_mix_row r;
        int chans, kind;
        logic [LEN_W-1:0] top;
        kind = $urandom_range(99);
        top = (ramp_len == 0) ? LEN_W'(1) : ramp_len;
        r = '0;
        if (kind < 2) begin
            // enough full-scale channels that the 24-bit sum wraps
            chans = $urandom_range(33, 40);
            r.gn = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
            for (int c = 0; c < chans; c++) begin
                r.smp  = 16'sh8000;
                r.pos  = POS_MIDDLE;
                r.idx  = INDEX_W'($urandom);
                r.last = (c == chans - 1);
                send_row(r);
            end
        end else if (kind < 10) begin
            // class none only, no sample comes out
            chans = $urandom_range(1, 4);
            for (int c = 0; c < chans; c++) begin
                r.smp  = SAMPLE_W'($urandom);
                r.gn   = GAIN_W'($urandom);
                r.pos  = POS_NONE;
                r.idx  = INDEX_W'($urandom);
                r.last = (c == chans - 1);
                send_row(r);
            end
        end else begin
            chans = $urandom_range(1, 8);
            for (int c = 0; c < chans; c++) begin
                case ($urandom_range(9))
                    0:       r.smp = 16'sh7FFF;
                    1:       r.smp = 16'sh8000;
                    default: r.smp = SAMPLE_W'($urandom);
                endcase
                case ($urandom_range(9))
                    0:       r.gn = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                    1, 2, 3: r.gn = GAIN_W'($urandom_range(0, 16'h2000));
                    4, 5:    r.gn = -GAIN_W'($urandom_range(0, 16'h2000));
                    default: r.gn = GAIN_W'($urandom);
                endcase
                r.pos  = ($urandom_range(99) < 15) ? POS_NONE : POS_W'($urandom_range(1, 3));
                r.idx  = $urandom_range(1) ? INDEX_W'($urandom)
                                           : INDEX_W'($urandom_range(0, top));
                r.last = (c == chans - 1);
                send_row(r);
            end
        end
    endtask

    // receiver side stalls at random
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    // output checker: each transaction against the oldest expected sample
    always @(posedge i_clk) begin
        logic signed [OUT_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_mix.size() == 0) begin
                $error("mixed: unexpected transaction, actual %0d", $signed(m_axis_tdata));
                mismatch_count++;
            end else begin
                want = pending_mix.pop_front();
                if (m_axis_tdata !== want) begin
                    $error("mixed: expected %0d, actual %0d", want, $signed(m_axis_tdata));
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [LEN_W-1:0] ramp_plan [PHASES];
        logic [LEN_W-1:0] next_len;
        ramp_plan = '{LEN_RESET, 10'd0, 10'd1, 10'h3FF, 10'd0, 10'd3, 10'd700};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset ramp length
        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_row(DIRECTED_ROWS[i]);
        sent_items = 0;

        // random part, one ramp length per phase, extremes among them
        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                drain_block();
                next_len = (p == 4) ? LEN_W'($urandom_range(2, 1022)) : ramp_plan[p];
                i_cfg_wr_en   <= 1'b1;
                i_cfg_wr_data <= next_len;
                @(posedge i_clk);
                i_cfg_wr_en   <= 1'b0;
                ramp_len = next_len;
            end
            while (sent_items < (p + 1) * RANDOM_ITEMS / PHASES) begin
                // idling: receiver heavy, then sender heavy, then none
                if (sent_items < RANDOM_ITEMS / 3) begin
                    tx_idle_pct = 34;
                    rx_idle_pct = 68;
                end else if (sent_items < 2 * RANDOM_ITEMS / 3) begin
                    tx_idle_pct = 68;
                    rx_idle_pct = 34;
                end else begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                send_random_position();
            end
        end

        drain_block();
        if (mismatch_count == 0 && pending_mix.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/gfam_pkg.sv
hdl/gfam_ctrl.sv
hdl/gfam_dp.sv
hdl/gain_fade_audio_mixer_unit.sv
tb/gain_fade_audio_mixer_unit_test.sv
